// ----- rtl/sorted_run_merger_unit_assert.svh -----
// Assertion macros for the sorted run merger checker.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef SORTED_RUN_MERGER_UNIT_ASSERT_SVH
`define SORTED_RUN_MERGER_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define SRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srm check failed");

// next-cycle implication, held off during reset
`define SRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srm check failed");

`endif

// ----- rtl/srm_pkg.sv -----
// Shared constants and controller/datapath interface types for the sorted run merger.
// No dependencies.
`default_nettype none

package srm_pkg;

    localparam int WORD_W        = 32;   // data word width
    localparam int CNT_W         = 6;    // run length and counter width
    localparam int MAX_RUN_DEF   = 32;   // default store depth
    localparam logic [CNT_W-1:0] RUN_LEN_RESET = 6'd16;

    // commands from controller to datapath
    typedef struct packed {
        logic wr_a;        // store a run A word
        logic take_b;      // capture a run B word
        logic emit_a;      // send head of run A
        logic emit_b;      // send captured B word
        logic emit_flush;  // send head of run A during flush
        logic clear;       // end of merge, zero all counters
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic load_phase;  // run A still loading
        logic a_left;      // run A words not yet sent
        logic a_avail;     // head of A goes before the B word
        logic b_final;     // current B word is the last of run B
        logic flush_last;  // head of A is the final A word
        logic out_free;    // output register can take a word
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/srm_dpath.sv -----
// Datapath: run A store, counters, length register and output register.
// Depends on srm_pkg.
`default_nettype none

module srm_dpath #(
    parameter int MAX_RUN = srm_pkg::MAX_RUN_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wen,
    input  wire logic [srm_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  wire logic [srm_pkg::WORD_W-1:0]  i_word,
    input  wire srm_pkg::t_cmd               i_cmd,
    output srm_pkg::t_stat                   o_stat,
    input  wire logic                        i_m_tready,
    output logic                             o_m_tvalid,
    output logic [srm_pkg::WORD_W-1:0]       o_m_tdata,
    output logic                             o_m_tlast
);
    import srm_pkg::*;

    localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic [WORD_W-1:0] r_mem [MAX_RUN];
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] r_b;
    logic [CNT_W-1:0]  r_run_length;
    logic [CNT_W-1:0]  r_load_cnt;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_sec_cnt;
    logic              r_ovalid;
    logic [WORD_W-1:0] r_odata;
    logic              r_olast;

    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  ptr_inc;
    logic [CNT_W-1:0]  sec_inc;
    logic [AW-1:0]     rd_addr;
    logic              n_ovalid;
    logic [WORD_W-1:0] n_odata;
    logic              n_olast;

    // effective length: zero reads as one, clipped to the store depth
    always_comb begin
        len = r_run_length;
        if (r_run_length == '0) begin
            len = CNT_W'(1);
        end else if (r_run_length > CNT_W'(MAX_RUN)) begin
            len = CNT_W'(MAX_RUN);
        end
    end

    assign ptr_inc = r_ptr + CNT_W'(1);
    assign sec_inc = r_sec_cnt + CNT_W'(1);

    always_comb begin
        o_stat.load_phase = (r_load_cnt < len);
        o_stat.a_left     = (r_ptr < len);
        o_stat.a_avail    = (r_ptr < len) && (r_rd <= r_b);
        o_stat.b_final    = (sec_inc >= len);
        o_stat.flush_last = (ptr_inc >= len);
        o_stat.out_free   = !r_ovalid || i_m_tready;
    end

    // read ahead of the pointer when the head is consumed this cycle
    assign rd_addr = (i_cmd.emit_a || i_cmd.emit_flush) ? ptr_inc[AW-1:0] : r_ptr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem[r_load_cnt[AW-1:0]] <= i_word;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata  = r_odata;
        n_olast  = r_olast;
        if (i_cmd.emit_a) begin
            n_ovalid = 1'b1;
            n_odata  = r_rd;
            n_olast  = 1'b0;
        end else if (i_cmd.emit_b) begin
            n_ovalid = 1'b1;
            n_odata  = r_b;
            n_olast  = o_stat.b_final && !o_stat.a_left;
        end else if (i_cmd.emit_flush) begin
            n_ovalid = 1'b1;
            n_odata  = r_rd;
            n_olast  = o_stat.flush_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_length <= RUN_LEN_RESET;
            r_load_cnt   <= '0;
            r_ptr        <= '0;
            r_sec_cnt    <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (i_cfg_wen) begin
                r_run_length <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_load_cnt <= '0;
                r_ptr      <= '0;
                r_sec_cnt  <= '0;
            end else begin
                if (i_cmd.wr_a) begin
                    r_load_cnt <= r_load_cnt + CNT_W'(1);
                end
                if (i_cmd.emit_a || i_cmd.emit_flush) begin
                    r_ptr <= ptr_inc;
                end
                if (i_cmd.emit_b) begin
                    r_sec_cnt <= sec_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_b) begin
            r_b <= i_word;
        end
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire

// ----- rtl/srm_ctrl.sv -----
// Controller state machine: sequences loading, merging and flushing.
// Depends on srm_pkg.
`default_nettype none

module srm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire srm_pkg::t_stat  i_stat,
    output srm_pkg::t_cmd        o_cmd
);
    import srm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MERGE = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = o_s_tready && i_s_tvalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.load_phase) begin
                        o_cmd.wr_a = 1'b1;
                    end else begin
                        o_cmd.take_b = 1'b1;
                        n_state      = S_MERGE;
                    end
                end
            end
            S_MERGE: begin
                if (i_stat.out_free) begin
                    if (i_stat.a_avail) begin
                        o_cmd.emit_a = 1'b1;
                    end else begin
                        o_cmd.emit_b = 1'b1;
                        if (i_stat.b_final && i_stat.a_left) begin
                            n_state = S_FLUSH;
                        end else begin
                            o_cmd.clear = i_stat.b_final;
                            n_state     = S_IDLE;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_flush = 1'b1;
                    if (i_stat.flush_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sorted_run_merger_unit.sv -----
// Top level of the sorted run merger: two-way merge of ascending word runs.
// Depends on srm_pkg, srm_ctrl and srm_dpath.
//
//  channel  | direction | signals                          | transaction
//  ---------+-----------+----------------------------------+---------------------------
//  s (in)   | slave     | i_s_tvalid o_s_tready i_s_tdata  | one word, run A then run B
//  m (out)  | master    | o_m_tvalid i_m_tready o_m_tdata  | one merged word
//           |           | o_m_tlast                        |   tlast on the final word
//  cfg      | write     | i_cfg_wen i_cfg_wdata            | run_length, no handshake
//
// Run A words are written into the run A store and produce nothing; input stays open for the next.
// A run B word is accepted, then merged words are sent one by one while output is free:
// the A words at or below it, the B word, and on the last B word the rest of A.
// The pace is set by the single read port of the run A store and the output register.
// Reset is synchronous and active low; the store itself is not cleared.
// A stalled output holds the state machine; input is taken only while idle.
`default_nettype none

module sorted_run_merger_unit #(
    parameter int MAX_RUN = srm_pkg::MAX_RUN_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration: run_length
    input  wire logic                        i_cfg_wen,
    input  wire logic [srm_pkg::CNT_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [srm_pkg::WORD_W-1:0]  i_s_tdata,   // [31:0] word
    // output stream
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [srm_pkg::WORD_W-1:0]       o_m_tdata,   // [31:0] merged_word
    output logic                             o_m_tlast
);
    import srm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // control: load / merge / flush sequencing
    srm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // storage, counters, compare and output register
    srm_dpath #(
        .MAX_RUN (MAX_RUN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word      (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/srm_checker.sv -----
// Port-level checker for the sorted run merger, bound to the top level.
// Depends on srm_pkg and sorted_run_merger_unit_assert.svh.
`default_nettype none

`include "sorted_run_merger_unit_assert.svh"

module srm_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        o_s_tready,
    input  wire logic                        o_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire logic [srm_pkg::WORD_W-1:0]  o_m_tdata,
    input  wire logic                        o_m_tlast
);
    import srm_pkg::*;

    // stalled output keeps its transaction
    `SRM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `SRM_ASSERT_NEXT(a_out_stable, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tlast))
    // words are only produced while the input side is closed
    `SRM_ASSERT_NOW(a_emit_busy, $rose(o_m_tvalid), !$past(o_s_tready))
    // returning to idle always coincides with a word leaving the merge
    `SRM_ASSERT_NOW(a_idle_emit, $rose(o_s_tready), o_m_tvalid)

endmodule

bind sorted_run_merger_unit srm_checker u_srm_checker (.*);

`default_nettype wire
